@@ design/stereo_biquad_df1_filter_unit_macros.svh @@
// Assertion macros used by the checker file.
`ifndef STEREO_BIQUAD_DF1_FILTER_UNIT_MACROS_SVH
`define STEREO_BIQUAD_DF1_FILTER_UNIT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define SBQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also checks behavior across reset.
`define SBQ_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/sbq_pkg.sv @@
package sbq_pkg;

   localparam int SAMPLE_WIDTH = 24;
   localparam int COEF_WIDTH   = 32;
   localparam int CFRAC        = COEF_WIDTH - 4;
   localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH;
   // five products summed: three guard bits
   localparam int ACC_WIDTH    = PROD_WIDTH + 3;
   localparam int RND_WIDTH    = ACC_WIDTH - CFRAC;

   localparam int REQ_DATA_WIDTH = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_USER_WIDTH = 1;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = COEF_WIDTH;

   localparam logic [CSR_ADDR_WIDTH-1:0] REG_COEF_B0     = CSR_ADDR_WIDTH'(0);
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_COEF_B1     = CSR_ADDR_WIDTH'(1);
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_COEF_B2     = CSR_ADDR_WIDTH'(2);
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_COEF_A1     = CSR_ADDR_WIDTH'(3);
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_COEF_A2     = CSR_ADDR_WIDTH'(4);
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_ACTIVE      = CSR_ADDR_WIDTH'(5);
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_STEREO_MODE = CSR_ADDR_WIDTH'(6);

   localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF = ACC_WIDTH'(1) << (CFRAC - 1);

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [COEF_WIDTH-1:0]   coef_type;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   typedef struct packed {
      coef_type b0;
      coef_type b1;
      coef_type b2;
      coef_type a1;
      coef_type a2;
   } coef_set_type;

   typedef struct packed {
      coef_set_type coefs;
      logic         active;
      logic         stereo_mode;
   } cfg_type;

endpackage

@@ design/sbq_csr.sv @@
module sbq_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wen,
   input  logic [sbq_pkg::CSR_ADDR_WIDTH-1:0]   csr_addr,
   input  logic [sbq_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output sbq_pkg::cfg_type                     cfg
);

   sbq_pkg::cfg_type cfg_ff;
   sbq_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_addr)
            sbq_pkg::REG_COEF_B0:     cfg_in.coefs.b0 = csr_wdata[sbq_pkg::COEF_WIDTH-1:0];
            sbq_pkg::REG_COEF_B1:     cfg_in.coefs.b1 = csr_wdata[sbq_pkg::COEF_WIDTH-1:0];
            sbq_pkg::REG_COEF_B2:     cfg_in.coefs.b2 = csr_wdata[sbq_pkg::COEF_WIDTH-1:0];
            sbq_pkg::REG_COEF_A1:     cfg_in.coefs.a1 = csr_wdata[sbq_pkg::COEF_WIDTH-1:0];
            sbq_pkg::REG_COEF_A2:     cfg_in.coefs.a2 = csr_wdata[sbq_pkg::COEF_WIDTH-1:0];
            sbq_pkg::REG_ACTIVE:      cfg_in.active = csr_wdata[0];
            sbq_pkg::REG_STEREO_MODE: cfg_in.stereo_mode = csr_wdata[0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // coefficients zero, bypass, stereo
         cfg_ff <= {sbq_pkg::coef_set_type'('0), 1'b0, 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ design/sbq_channel.sv @@
module sbq_channel (
   input  logic                  clock,
   input  logic                  reset,
   input  sbq_pkg::sample_type   x,
   input  sbq_pkg::coef_set_type coefs,
   input  logic                  filt,
   input  logic                  update,
   output sbq_pkg::sample_type   y,
   output logic                  clip
);

   sbq_pkg::sample_type x1_ff, x2_ff, y1_ff, y2_ff;
   sbq_pkg::sample_type x1_in, x2_in, y1_in, y2_in;

   logic signed [sbq_pkg::PROD_WIDTH-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
   logic signed [sbq_pkg::ACC_WIDTH-1:0]  acc_sum;
   logic signed [sbq_pkg::RND_WIDTH-1:0]  rounded;
   logic [sbq_pkg::RND_WIDTH-sbq_pkg::SAMPLE_WIDTH:0] upper;
   logic                                  fits;
   sbq_pkg::sample_type                   y_filt;

   assign p_b0 = x * coefs.b0;
   assign p_b1 = x1_ff * coefs.b1;
   assign p_b2 = x2_ff * coefs.b2;
   assign p_a1 = y1_ff * coefs.a1;
   assign p_a2 = y2_ff * coefs.a2;

   always_comb begin
      acc_sum = p_b0 + p_b1 + p_b2 - p_a1 - p_a2 + sbq_pkg::ROUND_HALF;
      rounded = acc_sum[sbq_pkg::ACC_WIDTH-1:sbq_pkg::CFRAC];
      // in range when every bit from the sample sign upward agrees
      upper   = rounded[sbq_pkg::RND_WIDTH-1:sbq_pkg::SAMPLE_WIDTH-1];
      fits    = (&upper) || !(|upper);
      if (fits) begin
         y_filt = rounded[sbq_pkg::SAMPLE_WIDTH-1:0];
      end else if (rounded[sbq_pkg::RND_WIDTH-1]) begin
         y_filt = sbq_pkg::SAMPLE_MIN;
      end else begin
         y_filt = sbq_pkg::SAMPLE_MAX;
      end
   end

   assign y    = filt ? y_filt : x;
   assign clip = filt && !fits;

   always_comb begin
      x1_in = x1_ff;
      x2_in = x2_ff;
      y1_in = y1_ff;
      y2_in = y2_ff;
      if (update) begin
         x1_in = x;
         x2_in = x1_ff;
         y2_in = y1_ff;
         y1_in = filt ? y_filt : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
      end else begin
         x1_ff <= x1_in;
         x2_ff <= x2_in;
         y1_ff <= y1_in;
         y2_ff <= y2_in;
      end
   end

endmodule

@@ design/stereo_biquad_df1_filter_unit.sv @@
// Stereo biquad (Direct Form I) filter. Sustains one transaction per clock when
// the result side is not stalled; each accepted sample pair passes the input
// and result registers in turn. The cycle time is set by the feedback path from
// each channel's history registers through its five parallel multipliers,
// the accumulator, rounding and saturation back into the history. An input
// register and a result register separate the two stream sides, so a new pair
// is taken while a finished result waits. Coefficient and mode registers are
// written through the csr_ port; write them only while no transaction is
// in flight.
module stereo_biquad_df1_filter_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [23:0] sample_left, [47:24] sample_right
   input  logic [sbq_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [23:0] out_left, [47:24] out_right
   output logic [sbq_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   // [0] saturated
   output logic [sbq_pkg::RSP_USER_WIDTH-1:0]  rsp_tuser,
   input  logic                                csr_wen,
   input  logic [sbq_pkg::CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  logic [sbq_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int SW = sbq_pkg::SAMPLE_WIDTH;

   sbq_pkg::cfg_type    cfg;

   logic                in_valid_ff, in_valid_in;
   sbq_pkg::sample_type left_ff, right_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   sbq_pkg::sample_type out_left_ff, out_right_ff;
   logic                sat_ff;

   logic                move;
   logic                req_take;
   sbq_pkg::sample_type left_y, right_y, out_right;
   logic                left_clip, right_clip, sat;

   sbq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign move       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || move;
   assign req_take   = req_tvalid && req_tready;

   sbq_channel u_left (
      .clock  (clock),
      .reset  (reset),
      .x      (left_ff),
      .coefs  (cfg.coefs),
      .filt   (cfg.active),
      .update (move),
      .y      (left_y),
      .clip   (left_clip)
   );

   // in mono mode the right history is frozen and the sample passes through
   sbq_channel u_right (
      .clock  (clock),
      .reset  (reset),
      .x      (right_ff),
      .coefs  (cfg.coefs),
      .filt   (cfg.active),
      .update (move && cfg.stereo_mode),
      .y      (right_y),
      .clip   (right_clip)
   );

   assign out_right = cfg.stereo_mode ? right_y : right_ff;
   assign sat       = left_clip || (cfg.stereo_mode && right_clip);

   assign in_valid_in  = req_take || (in_valid_ff && !move);
   assign rsp_valid_in = move || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         left_ff  <= req_tdata[SW-1:0];
         right_ff <= req_tdata[2*SW-1:SW];
      end
      if (move) begin
         out_left_ff  <= left_y;
         out_right_ff <= out_right;
         sat_ff       <= sat;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = sbq_pkg::RSP_DATA_WIDTH'({out_right_ff, out_left_ff});
   assign rsp_tuser  = sbq_pkg::RSP_USER_WIDTH'(sat_ff);

endmodule

@@ design/sbq_checker.sv @@
`include "stereo_biquad_df1_filter_unit_macros.svh"

module sbq_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [sbq_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input logic [sbq_pkg::RSP_USER_WIDTH-1:0]  rsp_tuser
);

   // a stalled result holds its payload
   `SBQ_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   // reset empties both stages
   `SBQ_ASSERT_RST(a_reset_empty, reset |=> !rsp_tvalid && req_tready, "pipeline not empty after reset")

   // input side only backs up when a result is waiting and stalled
   `SBQ_ASSERT(a_ready_backpressure, !req_tready |-> rsp_tvalid && !rsp_tready, "input stalled without output backpressure")

   // an accepted pair reaches the output when the sink drains
   `SBQ_ASSERT(a_latency, req_tvalid && req_tready ##1 rsp_tready |=> rsp_tvalid, "accepted transaction did not produce a result")

endmodule

bind stereo_biquad_df1_filter_unit sbq_checker u_sbq_checker (.*);

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import sbq_pkg::*;

   localparam int LEFT_CH  = 0;
   localparam int RIGHT_CH = 1;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_UNUSED = CSR_ADDR_WIDTH'(7);
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_PAIRS = 50;

   localparam coef_type COEF_ONE     = 32'sh1000_0000;
   localparam coef_type COEF_HALF    = 32'sh0800_0000;
   localparam coef_type COEF_QUARTER = 32'sh0400_0000;
   localparam coef_type COEF_MAX     = 32'sh7fff_ffff;
   localparam coef_type COEF_MIN     = 32'sh8000_0000;
   localparam longint ROUND_BIAS = longint'(1) << (CFRAC - 1);

   typedef struct {
      sample_type left;
      sample_type right;
      bit         saturated;
   } filtered_pair_type;

   class biquad_scoreboard;
      coef_type b0, b1, b2, a1, a2;
      bit filter_on;
      bit both_channels;
      sample_type x1[2], x2[2], y1[2], y2[2];
      filtered_pair_type awaited[$];
      int errors;

      function new();
         b0 = '0;
         b1 = '0;
         b2 = '0;
         a1 = '0;
         a2 = '0;
         filter_on = 1'b0;
         both_channels = 1'b1;
         foreach (x1[i]) begin
            x1[i] = '0;
            x2[i] = '0;
            y1[i] = '0;
            y2[i] = '0;
         end
         errors = 0;
      endfunction

      function void apply_register(logic [CSR_ADDR_WIDTH-1:0] addr,
                                   logic [CSR_DATA_WIDTH-1:0] data);
         case (addr)
            REG_COEF_B0:     b0 = coef_type'(data);
            REG_COEF_B1:     b1 = coef_type'(data);
            REG_COEF_B2:     b2 = coef_type'(data);
            REG_COEF_A1:     a1 = coef_type'(data);
            REG_COEF_A2:     a2 = coef_type'(data);
            REG_ACTIVE:      filter_on = data[0];
            REG_STEREO_MODE: both_channels = data[0];
            default: ;
         endcase
      endfunction

      // one biquad step for a channel, history shifted in place
      function sample_type filter_channel(int ch, sample_type x, output bit clipped);
         longint acc;
         sample_type y;
         clipped = 1'b0;
         if (filter_on) begin
            acc = longint'(b0) * longint'(x)
                + longint'(b1) * longint'(x1[ch])
                + longint'(b2) * longint'(x2[ch])
                - longint'(a1) * longint'(y1[ch])
                - longint'(a2) * longint'(y2[ch]);
            acc = (acc + ROUND_BIAS) >>> CFRAC;
            if (acc > longint'(SAMPLE_MAX)) begin
               y = SAMPLE_MAX;
               clipped = 1'b1;
            end else if (acc < longint'(SAMPLE_MIN)) begin
               y = SAMPLE_MIN;
               clipped = 1'b1;
            end else begin
               y = sample_type'(acc);
            end
            y2[ch] = y1[ch];
            y1[ch] = y;
         end else begin
            // bypass: output history shifts in zero
            y = x;
            y2[ch] = y1[ch];
            y1[ch] = '0;
         end
         x2[ch] = x1[ch];
         x1[ch] = x;
         return y;
      endfunction

      function void take_input_pair(logic [REQ_DATA_WIDTH-1:0] data);
         filtered_pair_type p;
         bit clip_l, clip_r;
         sample_type l, r;
         l = data[SAMPLE_WIDTH-1:0];
         r = data[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
         p.left = filter_channel(LEFT_CH, l, clip_l);
         if (both_channels) begin
            p.right = filter_channel(RIGHT_CH, r, clip_r);
         end else begin
            // mono: right passes through, its history untouched
            p.right = r;
            clip_r = 1'b0;
         end
         p.saturated = clip_l | clip_r;
         awaited.push_back(p);
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void check_output_pair(logic [RSP_DATA_WIDTH-1:0] data,
                                      logic [RSP_USER_WIDTH-1:0] user);
         filtered_pair_type exp;
         sample_type got_left, got_right;
         got_left = data[SAMPLE_WIDTH-1:0];
         got_right = data[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
         if (awaited.size() == 0) begin
            $error("unexpected output transaction: left %0d right %0d", got_left, got_right);
            errors++;
         end else begin
            exp = awaited.pop_front();
            if (got_left !== exp.left) begin
               $error("out_left: expected %0d, got %0d", exp.left, got_left);
               errors++;
            end
            if (got_right !== exp.right) begin
               $error("out_right: expected %0d, got %0d", exp.right, got_right);
               errors++;
            end
            if (user[0] !== exp.saturated) begin
               $error("saturated: expected %0b, got %0b", exp.saturated, user[0]);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [RSP_USER_WIDTH-1:0] rsp_tuser;
   logic csr_wen;
   logic [CSR_ADDR_WIDTH-1:0] csr_addr;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata;

   biquad_scoreboard sb;
   bit req_no_idle;
   bit rsp_no_stall;
   int rsp_stall_left = 0;
   int cycle_count = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   stereo_biquad_df1_filter_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // mostly short gaps, now and then a long one
   function automatic int next_gap(bit no_idle);
      int r;
      r = $urandom_range(99);
      if (no_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic sample_type random_sample();
      int r;
      r = $urandom_range(19);
      case (r)
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return '0;
         3: return '1;
         4, 5, 6, 7, 8: return sample_type'($urandom_range(0, 2000)) - sample_type'(1000);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic coef_type random_coef();
      int r;
      r = $urandom_range(9);
      case (r)
         0: return COEF_MAX;
         1: return COEF_MIN;
         2: return '0;
         3, 4, 5: return coef_type'($urandom);
         // within +/-1.0, keeps most outputs unclipped
         default: return coef_type'($urandom_range(0, 32'h2000_0000)) - COEF_ONE;
      endcase
   endfunction

   task automatic send_pair(input sample_type l, input sample_type r);
      int gap;
      gap = next_gap(req_no_idle);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= REQ_DATA_WIDTH'({r, l});
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   // caller lowers csr_wen after the last write
   task automatic put_reg(input logic [CSR_ADDR_WIDTH-1:0] addr,
                          input logic [CSR_DATA_WIDTH-1:0] data);
      csr_wen <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // one-bit registers get junk in the upper bits
   task automatic program_filter(input coef_type b0, input coef_type b1, input coef_type b2,
                                 input coef_type a1, input coef_type a2,
                                 input bit act, input bit stereo);
      put_reg(REG_COEF_B0, b0);
      put_reg(REG_COEF_B1, b1);
      put_reg(REG_COEF_B2, b2);
      put_reg(REG_COEF_A1, a1);
      put_reg(REG_COEF_A2, a2);
      put_reg(REG_ACTIVE, (CSR_DATA_WIDTH'($urandom) & ~CSR_DATA_WIDTH'(1))
                          | CSR_DATA_WIDTH'(act));
      put_reg(REG_STEREO_MODE, (CSR_DATA_WIDTH'($urandom) & ~CSR_DATA_WIDTH'(1))
                               | CSR_DATA_WIDTH'(stereo));
      if ($urandom_range(2) == 0) put_reg(REG_UNUSED, CSR_DATA_WIDTH'($urandom));
      csr_wen <= 1'b0;
   endtask

   task automatic run_random_phase(input int n);
      wait_idle();
      req_no_idle = ($urandom_range(4) == 0);
      rsp_no_stall = ($urandom_range(4) == 0);
      program_filter(random_coef(), random_coef(), random_coef(), random_coef(),
                     random_coef(), $urandom_range(3) != 0, $urandom_range(9) < 7);
      repeat (n) send_pair(random_sample(), random_sample());
   endtask

   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else begin
         rsp_stall_left <= next_gap(rsp_no_stall);
         rsp_tready <= 1'b1;
      end
   end

   // config, input and output transactions all seen at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wen) sb.apply_register(csr_addr, csr_wdata);
         if (req_tvalid && req_tready) sb.take_input_pair(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_output_pair(rsp_tdata, rsp_tuser);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("timeout with %0d outputs outstanding", sb.pending());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wen = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      req_no_idle = 1'b0;
      rsp_no_stall = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset config: bypass on both channels
      send_pair('0, '0);
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      send_pair(SAMPLE_MIN, SAMPLE_MAX);
      send_pair('1, sample_type'(1));
      send_pair(sample_type'(1), '1);

      // unity gain plus half of the bypass-era input history
      wait_idle();
      program_filter(COEF_ONE, COEF_HALF, '0, '0, '0, 1'b1, 1'b1);
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      send_pair(sample_type'(12345), -sample_type'(12345));
      send_pair(SAMPLE_MIN, SAMPLE_MAX);

      // extreme coefficients, clipping both ways
      wait_idle();
      program_filter(COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, 1'b1, 1'b1);
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      send_pair(SAMPLE_MIN, SAMPLE_MAX);
      send_pair(sample_type'(1), '1);
      send_pair('0, '0);

      // mono: right passes, its state frozen
      wait_idle();
      program_filter(COEF_QUARTER, COEF_HALF, -COEF_QUARTER, -COEF_HALF, COEF_QUARTER,
                     1'b1, 1'b0);
      repeat (4) send_pair(random_sample(), random_sample());

      // mono bypass
      wait_idle();
      program_filter(COEF_ONE, COEF_ONE, COEF_ONE, '0, '0, 1'b0, 1'b0);
      send_pair(SAMPLE_MIN, SAMPLE_MAX);
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      send_pair(random_sample(), random_sample());

      repeat (RANDOM_PHASES) run_random_phase(PHASE_PAIRS);

      wait_idle();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
